/* hdl/bads_pkg.sv */
package bads_pkg;

	localparam int GRID_DEF    = 16;
	localparam int MAX_DIM_DEF = 4096;

	localparam int DIM_W     = 13;
	localparam int CH_W      = 8;
	localparam int POS_W     = 4;
	localparam int SUM_W     = 24;
	localparam int QDEPTH    = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
	localparam logic [DIM_W-1:0]     DIM_RESET  = 13'd256;

	localparam logic [CH_W-1:0] AVG_MIN = 8'd0;
	localparam logic [CH_W-1:0] AVG_MAX = 8'd255;
	localparam logic [CH_W-1:0] MAP_MIN = 8'd10;
	localparam logic [CH_W-1:0] MAP_MAX = 8'd250;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_start;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0]  avg_red;
		logic [CH_W-1:0]  avg_green;
		logic [CH_W-1:0]  avg_blue;
		logic [POS_W-1:0] block_row;
		logic [POS_W-1:0] block_col;
		logic             frame_done;
	} result_t;

	// finished block handed from front to divider
	typedef struct packed {
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} job_t;

	function automatic logic [CH_W-1:0] remap(input logic [CH_W-1:0] avg);
		logic [CH_W-1:0] r;
		r = avg;
		if (avg == AVG_MIN) begin
			r = MAP_MIN;
		end else if (avg == AVG_MAX) begin
			r = MAP_MAX;
		end
		return r;
	endfunction

endpackage

/* hdl/block_average_downscale_16x16_top.sv */
// Block-average downscaler: RGB pixels enter in raster order through the push/full
// side, one per cycle while full is low, and each block of a GRID-by-GRID grid over
// the image yields one word of remapped channel averages on the empty/pop side.
// Averages are truncating divisions done by a shared radix-2 divider that handles all
// three channels together, one finished block at a time; up to QDEPTH = 4 finished
// blocks wait in a queue ahead of it, and full rises when that queue is full, which
// happens when block ends arrive faster than the divider clears them or when words
// are left waiting on the empty/pop side. Each write of image_width or image_height
// holds full high while the block position is recomputed from the pixel position by
// repeated subtraction.
module block_average_downscale_16x16_top #(
	parameter int GRID    = bads_pkg::GRID_DEF,
	parameter int MAX_DIM = bads_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  bads_pkg::pixel_t               pixel,
	output logic                           empty,
	input  logic                           pop,
	output bads_pkg::result_t              result,
	input  logic                           cfg_wr,
	input  logic [bads_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [bads_pkg::DIM_W-1:0]     cfg_data
);
	import bads_pkg::*;

	localparam int BW_W = $clog2(MAX_DIM / GRID + 1);
	localparam logic [DIM_W:0] MAX_DIM_X = (DIM_W + 1)'(MAX_DIM);

	logic [DIM_W-1:0] width_q, height_q, eff_w, eff_h;
	logic [BW_W-1:0]  blk_w, blk_h;
	logic             q_full, q_empty, q_pop, job_push;
	job_t             job, q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign eff_w = ({1'b0, width_q} > MAX_DIM_X) ? MAX_DIM_X[DIM_W-1:0] : width_q;
	assign eff_h = ({1'b0, height_q} > MAX_DIM_X) ? MAX_DIM_X[DIM_W-1:0] : height_q;
	assign blk_w = BW_W'(eff_w / GRID);
	assign blk_h = BW_W'(eff_h / GRID);

	bads_front #(
		.GRID    (GRID),
		.MAX_DIM (MAX_DIM),
		.BW_W    (BW_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.cfg_wr   (cfg_wr),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.blk_w    (blk_w),
		.blk_h    (blk_h),
		.q_full   (q_full),
		.job_push (job_push),
		.job      (job)
	);

	bads_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.din    (job),
		.full   (q_full),
		.rd     (q_pop),
		.dout   (q_job),
		.empty  (q_empty)
	);

	bads_div #(
		.GRID    (GRID),
		.MAX_DIM (MAX_DIM),
		.BW_W    (BW_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_w   (blk_w),
		.blk_h   (blk_h),
		.q_empty (q_empty),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_cfg_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> full)
		else $error("input taken right after a register write");

	a_done_is_last_block: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.frame_done) |->
			(result.block_row == POS_W'(GRID - 1)) && (result.block_col == POS_W'(GRID - 1)))
		else $error("frame_done on a block that is not the last one");

	a_avg_remapped: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |->
			(result.avg_red != AVG_MIN) && (result.avg_red != AVG_MAX)
			&& (result.avg_green != AVG_MIN) && (result.avg_green != AVG_MAX)
			&& (result.avg_blue != AVG_MIN) && (result.avg_blue != AVG_MAX))
		else $error("average word not remapped");

endmodule

/* hdl/bads_fifo.sv */
module bads_fifo #(
	parameter int DEPTH = bads_pkg::QDEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  bads_pkg::job_t din,
	output logic           full,
	input  logic           rd,
	output bads_pkg::job_t dout,
	output logic           empty
);
	import bads_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/bads_front.sv */
module bads_front #(
	parameter int GRID    = bads_pkg::GRID_DEF,
	parameter int MAX_DIM = bads_pkg::MAX_DIM_DEF,
	parameter int BW_W    = $clog2(MAX_DIM / GRID + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  bads_pkg::pixel_t           pixel,
	input  logic                       cfg_wr,
	input  logic [bads_pkg::DIM_W-1:0] eff_w,
	input  logic [bads_pkg::DIM_W-1:0] eff_h,
	input  logic [BW_W-1:0]            blk_w,
	input  logic [BW_W-1:0]            blk_h,
	input  logic                       q_full,
	output logic                       job_push,
	output bads_pkg::job_t             job
);
	import bads_pkg::*;

	localparam int CW   = $clog2(MAX_DIM);
	localparam int BC_W = $clog2(GRID + 1);
	localparam int GI_W = $clog2(GRID);

	typedef enum logic [1:0] {
		S_RUN  = 2'b01,
		S_SYNC = 2'b10
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     x_q, y_q, rx_q, ry_q;
	logic [BW_W-1:0]   xin_q, yin_q;
	logic [BC_W-1:0]   bc_q, br_q;
	logic [SUM_W-1:0]  sum_r_q [GRID];
	logic [SUM_W-1:0]  sum_g_q [GRID];
	logic [SUM_W-1:0]  sum_b_q [GRID];

	logic              accept, fs, in_blk, blk_end, xin_last, yin_last;
	logic              row_wrap, frame_wrap, step_x, step_y;
	logic [CW-1:0]     x_e, y_e;
	logic [BW_W-1:0]   xin_e, yin_e;
	logic [BC_W-1:0]   bc_e, br_e;
	logic [GI_W-1:0]   idx;
	logic [DIM_W:0]    x_inc, y_inc;
	logic [SUM_W-1:0]  new_r, new_g, new_b;

	assign accept = push && !full;
	assign full   = q_full || (state_q != S_RUN);
	assign fs     = pixel.frame_start;

	assign x_e   = fs ? '0 : x_q;
	assign y_e   = fs ? '0 : y_q;
	assign xin_e = fs ? '0 : xin_q;
	assign yin_e = fs ? '0 : yin_q;
	assign bc_e  = fs ? '0 : bc_q;
	assign br_e  = fs ? '0 : br_q;
	assign idx   = bc_e[GI_W-1:0];

	assign in_blk = (blk_w != '0) && (blk_h != '0)
		&& (bc_e < BC_W'(GRID)) && (br_e < BC_W'(GRID));
	assign xin_last = (xin_e == blk_w - 1'b1);
	assign yin_last = (yin_e == blk_h - 1'b1);
	assign blk_end  = in_blk && xin_last && yin_last;

	// frame start clears the sums before this pixel is added
	assign new_r = (fs ? '0 : sum_r_q[idx]) + SUM_W'(pixel.red);
	assign new_g = (fs ? '0 : sum_g_q[idx]) + SUM_W'(pixel.green);
	assign new_b = (fs ? '0 : sum_b_q[idx]) + SUM_W'(pixel.blue);

	assign x_inc      = (DIM_W + 1)'(x_e) + 1'b1;
	assign y_inc      = (DIM_W + 1)'(y_e) + 1'b1;
	assign row_wrap   = (x_inc >= {1'b0, eff_w});
	assign frame_wrap = (y_inc >= {1'b0, eff_h});

	// block position rebuilt from pixel position after a register write
	assign step_x = (blk_w != '0) && (rx_q >= CW'(blk_w)) && (bc_q < BC_W'(GRID));
	assign step_y = (blk_h != '0) && (ry_q >= CW'(blk_h)) && (br_q < BC_W'(GRID));

	assign job_push      = accept && blk_end;
	assign job.sum_red   = new_r;
	assign job.sum_green = new_g;
	assign job.sum_blue  = new_b;
	assign job.row       = POS_W'(br_e);
	assign job.col       = POS_W'(bc_e);
	assign job.done      = (br_e == BC_W'(GRID - 1)) && (bc_e == BC_W'(GRID - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			x_q     <= '0;
			y_q     <= '0;
			rx_q    <= '0;
			ry_q    <= '0;
			xin_q   <= '0;
			yin_q   <= '0;
			bc_q    <= '0;
			br_q    <= '0;
		end else if (cfg_wr) begin
			state_q <= S_SYNC;
			rx_q    <= x_q;
			ry_q    <= y_q;
			bc_q    <= '0;
			br_q    <= '0;
		end else begin
			case (state_q)
				S_RUN: begin
					if (accept) begin
						if (row_wrap) begin
							x_q   <= '0;
							xin_q <= '0;
							bc_q  <= '0;
							if (frame_wrap) begin
								y_q   <= '0;
								yin_q <= '0;
								br_q  <= '0;
							end else begin
								y_q <= CW'(y_inc);
								if (yin_last) begin
									yin_q <= '0;
									br_q  <= (br_e == BC_W'(GRID)) ? br_e : br_e + 1'b1;
								end else begin
									yin_q <= yin_e + 1'b1;
									br_q  <= br_e;
								end
							end
						end else begin
							x_q   <= CW'(x_inc);
							y_q   <= y_e;
							yin_q <= yin_e;
							br_q  <= br_e;
							if (xin_last) begin
								xin_q <= '0;
								bc_q  <= (bc_e == BC_W'(GRID)) ? bc_e : bc_e + 1'b1;
							end else begin
								xin_q <= xin_e + 1'b1;
								bc_q  <= bc_e;
							end
						end
					end
				end
				S_SYNC: begin
					if (step_x) begin
						rx_q <= rx_q - CW'(blk_w);
						bc_q <= bc_q + 1'b1;
					end
					if (step_y) begin
						ry_q <= ry_q - CW'(blk_h);
						br_q <= br_q + 1'b1;
					end
					if (!step_x && !step_y) begin
						xin_q   <= BW_W'(rx_q);
						yin_q   <= BW_W'(ry_q);
						state_q <= S_RUN;
					end
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GRID; i++) begin
				sum_r_q[i] <= '0;
				sum_g_q[i] <= '0;
				sum_b_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < GRID; i++) begin
				if (in_blk && (idx == GI_W'(i))) begin
					sum_r_q[i] <= blk_end ? '0 : new_r;
					sum_g_q[i] <= blk_end ? '0 : new_g;
					sum_b_q[i] <= blk_end ? '0 : new_b;
				end else if (fs) begin
					sum_r_q[i] <= '0;
					sum_g_q[i] <= '0;
					sum_b_q[i] <= '0;
				end
			end
		end
	end

endmodule

/* hdl/bads_div.sv */
module bads_div #(
	parameter int GRID    = bads_pkg::GRID_DEF,
	parameter int MAX_DIM = bads_pkg::MAX_DIM_DEF,
	parameter int BW_W    = $clog2(MAX_DIM / GRID + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BW_W-1:0]   blk_w,
	input  logic [BW_W-1:0]   blk_h,
	input  logic              q_empty,
	input  bads_pkg::job_t    q_job,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output bads_pkg::result_t result
);
	import bads_pkg::*;

	localparam int N_W    = 2 * BW_W;
	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_CALC = 3'b010,
		D_DONE = 3'b100
	} dstate_t;

	dstate_t           state_q;
	logic [N_W-1:0]    n_q;
	logic [SUM_W-1:0]  quo_q [3];
	logic [N_W-1:0]    rem_q [3];
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  row_q, col_q;
	logic              done_q;
	result_t           res_q;
	logic              res_vld_q;

	logic [N_W:0]      sh   [3];
	logic [N_W+1:0]    dif  [3];
	logic [2:0]        ge;
	logic              slot_free;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sh[c]  = {rem_q[c], quo_q[c][SUM_W-1]};
			dif[c] = {1'b0, sh[c]} - {2'b00, n_q};
			ge[c]  = !dif[c][N_W+1];
		end
	end

	assign q_pop     = (state_q == D_IDLE) && !q_empty;
	assign slot_free = !res_vld_q || pop;
	assign empty     = !res_vld_q;
	assign result    = res_q;

	// pixels per block; registered from the block size, settling in the cycle after a register write
	always_ff @(posedge clk) begin
		n_q <= N_W'(blk_w) * N_W'(blk_h);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (!q_empty) begin
					quo_q[0] <= q_job.sum_red;
					quo_q[1] <= q_job.sum_green;
					quo_q[2] <= q_job.sum_blue;
					for (int c = 0; c < 3; c++) begin
						rem_q[c] <= '0;
					end
					row_q  <= q_job.row;
					col_q  <= q_job.col;
					done_q <= q_job.done;
				end
			end
			D_CALC: begin
				for (int c = 0; c < 3; c++) begin
					rem_q[c] <= ge[c] ? dif[c][N_W-1:0] : sh[c][N_W-1:0];
					quo_q[c] <= {quo_q[c][SUM_W-2:0], ge[c]};
				end
			end
			D_DONE: begin
				if (slot_free) begin
					res_q.avg_red    <= remap(quo_q[0][CH_W-1:0]);
					res_q.avg_green  <= remap(quo_q[1][CH_W-1:0]);
					res_q.avg_blue   <= remap(quo_q[2][CH_W-1:0]);
					res_q.block_row  <= row_q;
					res_q.block_col  <= col_q;
					res_q.frame_done <= done_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= D_IDLE;
			step_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (!q_empty) begin
						state_q <= D_CALC;
						step_q  <= '0;
					end
				end
				D_CALC: begin
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= D_DONE;
					end
					step_q <= step_q + 1'b1;
				end
				D_DONE: begin
					if (slot_free) begin
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
			if (state_q == D_DONE && slot_free) begin
				res_vld_q <= 1'b1;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

endmodule

/* tb/tb_block_average_downscale_16x16_top.sv */
module tb_block_average_downscale_16x16_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bads_pkg::*;

	localparam int SETTLE_CYCLES = 150;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	pixel_t               pixel;
	logic                 empty;
	logic                 pop;
	result_t              result;
	logic                 cfg_wr;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [DIM_W-1:0]     cfg_data;

	block_average_downscale_16x16_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_wr   (cfg_wr),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic [DIM_W-1:0] width_reg  = DIM_RESET;
	logic [DIM_W-1:0] height_reg = DIM_RESET;
	logic [SUM_W-1:0] acc_red   [GRID_DEF] = '{default: '0};
	logic [SUM_W-1:0] acc_green [GRID_DEF] = '{default: '0};
	logic [SUM_W-1:0] acc_blue  [GRID_DEF] = '{default: '0};
	logic [11:0]      col_pos = '0;
	logic [11:0]      row_pos = '0;

	result_t     averages_due[$];
	int unsigned mismatches   = 0;
	int unsigned area_pixels  = 0;
	bit          tx_gaps      = 1'b1;
	bit          rx_gaps      = 1'b1;
	int unsigned rx_hold      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [CH_W-1:0] remap_average(input logic [31:0] quot);
		case (quot[CH_W-1:0])
			AVG_MIN: return MAP_MIN;
			AVG_MAX: return MAP_MAX;
			default: return quot[CH_W-1:0];
		endcase
	endfunction

	// returns 1 when the pixel falls inside the whole-block area
	function automatic bit accumulate_pixel(input pixel_t px);
		int unsigned w, h, bw, bh, x, y, bc, br, n;
		logic [POS_W-1:0] bi;
		result_t blk;
		bit in_area;
		w = (32'(width_reg) > MAX_DIM_DEF) ? MAX_DIM_DEF : 32'(width_reg);
		h = (32'(height_reg) > MAX_DIM_DEF) ? MAX_DIM_DEF : 32'(height_reg);
		bw = w / GRID_DEF;
		bh = h / GRID_DEF;
		if (px.frame_start) begin
			col_pos = '0;
			row_pos = '0;
			for (int i = 0; i < GRID_DEF; i++) begin
				acc_red[i] = '0;
				acc_green[i] = '0;
				acc_blue[i] = '0;
			end
		end
		x = 32'(col_pos);
		y = 32'(row_pos);
		in_area = bw != 0 && bh != 0 && x < bw * GRID_DEF && y < bh * GRID_DEF;
		if (in_area) begin
			bc = x / bw;
			br = y / bh;
			bi = bc[POS_W-1:0];
			acc_red[bi] = acc_red[bi] + px.red;
			acc_green[bi] = acc_green[bi] + px.green;
			acc_blue[bi] = acc_blue[bi] + px.blue;
			if (x % bw == bw - 1 && y % bh == bh - 1) begin
				n = bw * bh;
				blk.avg_red = remap_average(acc_red[bi] / n);
				blk.avg_green = remap_average(acc_green[bi] / n);
				blk.avg_blue = remap_average(acc_blue[bi] / n);
				blk.block_row = br[POS_W-1:0];
				blk.block_col = bc[POS_W-1:0];
				blk.frame_done = (br == GRID_DEF - 1) && (bc == GRID_DEF - 1);
				averages_due.insert(averages_due.size(), blk);
				acc_red[bi] = '0;
				acc_green[bi] = '0;
				acc_blue[bi] = '0;
			end
		end
		x = x + 1;
		if (x >= w) begin
			x = 0;
			y = y + 1;
			if (y >= h) begin
				y = 0;
			end
		end
		col_pos = x[11:0];
		row_pos = y[11:0];
		return in_area;
	endfunction

	function automatic pixel_t make_pixel(input logic [CH_W-1:0] r, g, b, input bit fs);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.frame_start = fs;
		return px;
	endfunction

	function automatic logic [CH_W-1:0] random_channel();
		case ($urandom_range(0, 9))
			0: return AVG_MIN;
			1: return AVG_MAX;
			default: return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t random_pixel(input bit fs);
		return make_pixel(random_channel(), random_channel(), random_channel(), fs);
	endfunction

	function automatic void check_field(input string name, input int unsigned want, got);
		if (want != got) begin
			$display("%t %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_pixel(input pixel_t px);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		push <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (full) @(posedge clk);
		if (accumulate_pixel(px)) begin
			area_pixels++;
		end
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		@(posedge clk);
		while (averages_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned w, h);
		wait_drain();
		cfg_wr <= 1'b1;
		cfg_addr <= REG_WIDTH;
		cfg_data <= DIM_W'(w);
		@(posedge clk);
		cfg_addr <= REG_HEIGHT;
		cfg_data <= DIM_W'(h);
		@(posedge clk);
		cfg_wr <= 1'b0;
		width_reg = DIM_W'(w);
		height_reg = DIM_W'(h);
	endtask

	task automatic test_directed_corners();
		set_frame(16, 16);
		send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
		send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
		send_pixel(make_pixel(8'd1, 8'd254, 8'd128, 1'b0));
		send_pixel(make_pixel(8'hAA, 8'h55, 8'h0F, 1'b0));
		send_pixel(make_pixel(8'd254, 8'd1, 8'hF0, 1'b0));
		send_pixel(make_pixel(8'd7, 8'd8, 8'd9, 1'b1));
		// two-pixel blocks; last row lies outside the block area
		set_frame(32, 17);
		send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 1'b1));
		send_pixel(make_pixel(8'd1, 8'd254, 8'd255, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 1'b0));
		send_pixel(make_pixel(8'd254, 8'd0, 8'd1, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd128, 8'd3, 1'b0));
		send_pixel(make_pixel(8'd255, 8'd129, 8'd4, 1'b0));
		// block size zero: nothing comes out
		set_frame(15, 16);
		repeat (4) send_pixel(random_pixel(1'b0));
		set_frame(16, 0);
		repeat (3) send_pixel(random_pixel(1'b0));
		set_frame(0, 0);
		repeat (2) send_pixel(random_pixel(1'b1));
	endtask

	task automatic test_random_frames(input int unsigned target);
		int unsigned sel, n, w, h;
		bit fs;
		area_pixels = 0;
		while (area_pixels < target) begin
			sel = $urandom_range(0, 9);
			if (sel != 9) begin
				if (sel <= 5) begin
					w = $urandom_range(16, 20);
					h = $urandom_range(16, 20);
				end else if (sel <= 7) begin
					w = 16 * $urandom_range(2, 3) + $urandom_range(0, 2);
					h = $urandom_range(16, 18);
				end else begin
					w = $urandom_range(0, 8191);
					h = $urandom_range(0, 8191);
				end
				set_frame(w, h);
			end
			n = $urandom_range(10, 120);
			fs = (sel != 9) && ($urandom_range(0, 4) != 0);
			for (int i = 0; i < n; i++) begin
				send_pixel(random_pixel(i == 0 ? fs : ($urandom_range(0, 59) == 0)));
			end
		end
	endtask

	task automatic test_widest_row();
		// width clamps to the maximum: 256-pixel blocks, one row high
		set_frame(8191, 16);
		for (int i = 0; i < 260; i++) begin
			send_pixel(random_pixel(i == 0));
		end
		set_frame(4096, 8191);
		for (int i = 0; i < 8; i++) begin
			send_pixel(random_pixel(i == 0));
		end
	endtask

	task automatic test_output_stall();
		set_frame(16, 16);
		tx_gaps = 1'b0;
		rx_hold = 400;
		for (int i = 0; i < 48; i++) begin
			send_pixel(random_pixel(i == 0));
		end
		tx_gaps = 1'b1;
		wait_drain();
	endtask

	task automatic test_last_row_no_gaps();
		// one-pixel rows walk the row position down to the last block row
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_frame(1, 16);
		for (int i = 0; i < 15; i++) begin
			send_pixel(random_pixel(i == 0));
		end
		set_frame(16, 16);
		for (int i = 0; i < 16; i++) begin
			send_pixel(random_pixel(1'b0));
		end
	endtask

	initial begin : pop_drive
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold != 0) begin
				pop <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : result_check
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (averages_due.size() == 0) begin
					$display("%t unexpected word: expected none, got %h", $time, result);
					mismatches++;
				end else begin
					want = averages_due.pop_front();
					check_field("avg_red", 32'(want.avg_red), 32'(result.avg_red));
					check_field("avg_green", 32'(want.avg_green), 32'(result.avg_green));
					check_field("avg_blue", 32'(want.avg_blue), 32'(result.avg_blue));
					check_field("block_row", 32'(want.block_row), 32'(result.block_row));
					check_field("block_col", 32'(want.block_col), 32'(result.block_col));
					check_field("frame_done", 32'(want.frame_done), 32'(result.frame_done));
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		pixel <= '0;
		cfg_wr <= 1'b0;
		cfg_addr <= REG_WIDTH;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_frames(120);
		test_output_stall();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		test_widest_row();
		test_last_row_no_gaps();
		wait_drain();
		if (mismatches == 0 && averages_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
